[hw/rtl/csv_field_splitter_defines.svh]
// assertion helpers for the csv field splitter
`ifndef CSV_FIELD_SPLITTER_DEFINES_SVH
`define CSV_FIELD_SPLITTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CSVFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CSVFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/csvfs_pkg.sv]
package csvfs_pkg;

    localparam int MAX_FIELDS = 128;
    localparam int LEN_W      = 16;
    localparam int FCNT_W     = $clog2(MAX_FIELDS + 1);
    localparam int NUM_W      = 7;
    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;

    localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIELD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RECORD = 2'd2;

    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    localparam logic [FCNT_W-1:0] FCNT_LIMIT = FCNT_W'(MAX_FIELDS);
    localparam logic [NUM_W-1:0]  NUM_LAST   = NUM_W'(MAX_FIELDS - 1);
    localparam logic [LEN_W-1:0]  LEN_MAX    = {LEN_W{1'b1}};

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_input;
    } t_in_word;

    typedef struct packed {
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] out_byte;
        logic [NUM_W-1:0]  field_number;
        logic [LEN_W-1:0]  raw_length;
        logic              is_null;
        logic              field_overflow;
    } t_result;

    typedef struct packed {
        logic record_open;
        logic in_quote;
        logic quote_pending;
    } t_status;

endpackage

[hw/rtl/csvfs_in_reg.sv]
module csvfs_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  csvfs_pkg::t_in_word i_word,
    input  logic               i_take,
    output logic               o_valid,
    output csvfs_pkg::t_in_word o_word
);

    logic                r_valid;
    csvfs_pkg::t_in_word r_word;
    logic                n_valid;

    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

[hw/rtl/csvfs_core.sv]
module csvfs_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_advance,
    input  csvfs_pkg::t_in_word i_word,
    output csvfs_pkg::t_result  o_result,
    output csvfs_pkg::t_status  o_status
);

    logic                           r_null_if_empty;
    logic                           r_in_quote, n_in_quote;
    logic                           r_at_field_start, n_at_field_start;
    logic                           r_quote_pending, n_quote_pending;
    logic                           r_started_quoted, n_started_quoted;
    logic                           r_cr_pending, n_cr_pending;
    logic                           r_record_open, n_record_open;
    logic [csvfs_pkg::FCNT_W-1:0]   r_field_cnt, n_field_cnt;
    logic [csvfs_pkg::LEN_W-1:0]    r_len, n_len;

    logic [csvfs_pkg::LEN_W-1:0]    len_inc;
    logic [csvfs_pkg::BYTE_W-1:0]   b;
    logic                           pass_on;
    logic                           do_content;
    logic                           do_finish;
    logic                           finish_rec;
    logic                           ovf;
    logic                           nul;
    csvfs_pkg::t_result             res;

    assign b       = i_word.data_byte;
    assign len_inc = (r_len == csvfs_pkg::LEN_MAX) ? r_len : r_len + 1'b1;
    assign ovf     = r_field_cnt >= csvfs_pkg::FCNT_LIMIT;

    always_comb begin
        n_in_quote       = r_in_quote;
        n_at_field_start = r_at_field_start;
        n_quote_pending  = r_quote_pending;
        n_started_quoted = r_started_quoted;
        n_cr_pending     = r_cr_pending;
        n_record_open    = r_record_open;
        n_field_cnt      = r_field_cnt;
        n_len            = r_len;
        pass_on          = 1'b0;
        do_content       = 1'b0;
        do_finish        = 1'b0;
        finish_rec       = 1'b0;
        nul              = 1'b0;
        res              = '0;

        if (i_word.end_of_input) begin
            n_quote_pending = 1'b0;
            n_cr_pending    = 1'b0;
            if (r_quote_pending) begin
                n_in_quote = 1'b0;
            end
            if (!r_record_open) begin
                n_field_cnt      = '0;
                n_len            = '0;
                n_at_field_start = 1'b1;
                n_started_quoted = 1'b0;
                n_in_quote       = 1'b0;
            end else begin
                do_finish  = 1'b1;
                finish_rec = 1'b1;
            end
        end else if (r_quote_pending) begin
            n_quote_pending = 1'b0;
            if (b == csvfs_pkg::CH_QUOTE) begin
                // doubled quote gives one literal quote
                n_len      = len_inc;
                do_content = 1'b1;
            end else begin
                n_in_quote = 1'b0;
                pass_on    = 1'b1;
            end
        end else if (r_in_quote) begin
            n_len = len_inc;
            if (b == csvfs_pkg::CH_QUOTE) begin
                n_quote_pending = 1'b1;
            end else begin
                do_content = 1'b1;
            end
        end else begin
            pass_on = 1'b1;
        end

        if (pass_on) begin
            n_cr_pending = 1'b0;
            if (r_cr_pending && b == csvfs_pkg::CH_LF) begin
                // lf of a crlf pair is dropped
            end else if (b == csvfs_pkg::CH_CR || b == csvfs_pkg::CH_LF) begin
                n_cr_pending = (b == csvfs_pkg::CH_CR);
                if (r_record_open) begin
                    do_finish  = 1'b1;
                    finish_rec = 1'b1;
                end
            end else begin
                n_record_open = 1'b1;
                if (b == csvfs_pkg::CH_COMMA) begin
                    do_finish = 1'b1;
                end else begin
                    n_len = len_inc;
                    if (b == csvfs_pkg::CH_QUOTE && r_at_field_start) begin
                        n_in_quote       = 1'b1;
                        n_started_quoted = 1'b1;
                        n_at_field_start = 1'b0;
                    end else begin
                        n_at_field_start = 1'b0;
                        do_content       = 1'b1;
                    end
                end
            end
        end

        if (do_content && !ovf) begin
            res.emit         = 1'b1;
            res.kind         = csvfs_pkg::KIND_BYTE;
            res.out_byte     = b;
            res.field_number = r_field_cnt[csvfs_pkg::NUM_W-1:0];
        end

        if (do_finish) begin
            // bare quoted-empty field counts as null too
            nul = r_null_if_empty && ((r_len == '0) ||
                  (r_started_quoted && r_len == csvfs_pkg::LEN_W'(2) && !n_in_quote));
            if (finish_rec) begin
                res.emit = 1'b1;
                res.kind = csvfs_pkg::KIND_RECORD;
                if (ovf) begin
                    res.field_number   = csvfs_pkg::NUM_LAST;
                    res.field_overflow = 1'b1;
                end else begin
                    res.field_number = r_field_cnt[csvfs_pkg::NUM_W-1:0];
                    res.raw_length   = r_len;
                    res.is_null      = nul;
                end
                n_field_cnt   = '0;
                n_record_open = 1'b0;
            end else if (!ovf) begin
                res.emit         = 1'b1;
                res.kind         = csvfs_pkg::KIND_FIELD;
                res.field_number = r_field_cnt[csvfs_pkg::NUM_W-1:0];
                res.raw_length   = r_len;
                res.is_null      = nul;
                n_field_cnt      = r_field_cnt + 1'b1;
            end
            n_len            = '0;
            n_at_field_start = 1'b1;
            n_started_quoted = 1'b0;
            n_in_quote       = 1'b0;
            n_quote_pending  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_null_if_empty  <= 1'b0;
            r_in_quote       <= 1'b0;
            r_at_field_start <= 1'b1;
            r_quote_pending  <= 1'b0;
            r_started_quoted <= 1'b0;
            r_cr_pending     <= 1'b0;
            r_record_open    <= 1'b0;
            r_field_cnt      <= '0;
            r_len            <= '0;
        end else begin
            if (i_cfg_we) begin
                r_null_if_empty <= i_cfg_wdata;
            end
            if (i_advance) begin
                r_in_quote       <= n_in_quote;
                r_at_field_start <= n_at_field_start;
                r_quote_pending  <= n_quote_pending;
                r_started_quoted <= n_started_quoted;
                r_cr_pending     <= n_cr_pending;
                r_record_open    <= n_record_open;
                r_field_cnt      <= n_field_cnt;
                r_len            <= n_len;
            end
        end
    end

    assign o_result               = res;
    assign o_status.record_open   = r_record_open;
    assign o_status.in_quote      = r_in_quote;
    assign o_status.quote_pending = r_quote_pending;

endmodule

[hw/rtl/csvfs_out_reg.sv]
module csvfs_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_word_valid,
    input  csvfs_pkg::t_result i_result,
    input  logic               i_ready,
    output logic               o_valid,
    output logic               o_take,
    output csvfs_pkg::t_result o_result
);

    logic               r_valid, n_valid;
    csvfs_pkg::t_result r_result;

    // a word moves on whenever the result slot is free or being drained
    assign o_take = i_word_valid && (!r_valid || i_ready);

    always_comb begin
        n_valid = r_valid && !i_ready;
        if (o_take) begin
            n_valid = i_result.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_result.emit) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[hw/rtl/csv_field_splitter.sv]
// channel   direction  handshake                   payload
// in        input      i_in_valid / o_in_ready     i_data_byte, i_end_of_input
// out       output     o_out_valid / i_out_ready   o_kind .. o_field_overflow
// cfg       input      i_cfg_we (no wait)          i_cfg_wdata (null_if_empty)
//
// one word per cycle sustained while the output is not stalled; a word is held in
// the input register, and its result goes into the output register when taken
// the field state update is a single pass of logic between those two registers
// synchronous active-low reset, no clearing pass; accepts words right after reset
// a stalled output holds the result register and stops the input register only
// when it is full, so the input side stays ready while the input register is empty
`include "csv_field_splitter_defines.svh"

module csv_field_splitter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [csvfs_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                            i_end_of_input,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [csvfs_pkg::KIND_W-1:0]    o_kind,
    output logic [csvfs_pkg::BYTE_W-1:0]    o_out_byte,
    output logic [csvfs_pkg::NUM_W-1:0]     o_field_number,
    output logic [csvfs_pkg::LEN_W-1:0]     o_raw_length,
    output logic                            o_is_null,
    output logic                            o_field_overflow
);

    csvfs_pkg::t_in_word in_word;
    csvfs_pkg::t_in_word held_word;
    csvfs_pkg::t_result  next_result;
    csvfs_pkg::t_result  out_result;
    csvfs_pkg::t_status  status;
    logic                held_valid;
    logic                take;

    assign in_word.data_byte    = i_data_byte;
    assign in_word.end_of_input = i_end_of_input;

    csvfs_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (in_word),
        .i_take  (take),
        .o_valid (held_valid),
        .o_word  (held_word)
    );

    csvfs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_advance   (take),
        .i_word      (held_word),
        .o_result    (next_result),
        .o_status    (status)
    );

    csvfs_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word_valid (held_valid),
        .i_result     (next_result),
        .i_ready      (i_out_ready),
        .o_valid      (o_out_valid),
        .o_take       (take),
        .o_result     (out_result)
    );

    assign o_kind           = out_result.kind;
    assign o_out_byte       = out_result.out_byte;
    assign o_field_number   = out_result.field_number;
    assign o_raw_length     = out_result.raw_length;
    assign o_is_null        = out_result.is_null;
    assign o_field_overflow = out_result.field_overflow;

    `CSVFS_ASSERT_NOW(a_pending_in_quote, i_clk, i_rst_n, status.quote_pending, status.in_quote, "quote pending outside quotes")

    `CSVFS_ASSERT_NOW(a_byte_clean, i_clk, i_rst_n, o_out_valid && o_kind == csvfs_pkg::KIND_BYTE, o_raw_length == '0 && !o_is_null && !o_field_overflow, "content word carries field-end data")

    `CSVFS_ASSERT_NOW(a_overflow_record, i_clk, i_rst_n, o_out_valid && o_field_overflow, o_kind == csvfs_pkg::KIND_RECORD && o_field_number == csvfs_pkg::NUM_LAST, "overflow flag off a record end")

    `CSVFS_ASSERT_NEXT(a_eoi_closes, i_clk, i_rst_n, take && held_word.end_of_input, !status.record_open && !status.in_quote, "record left open after end of input")

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    typedef logic [csvfs_pkg::BYTE_W-1:0] t_byte;

    typedef struct packed {
        logic [csvfs_pkg::KIND_W-1:0] kind;
        logic [csvfs_pkg::BYTE_W-1:0] data;
        logic [csvfs_pkg::NUM_W-1:0]  num;
        logic [csvfs_pkg::LEN_W-1:0]  len;
        logic                         nul;
        logic                         ovf;
    } t_token;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic                         cfg_wdata = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [csvfs_pkg::BYTE_W-1:0] in_byte = '0;
    logic                         in_eoi = 1'b0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [csvfs_pkg::KIND_W-1:0] out_kind;
    logic [csvfs_pkg::BYTE_W-1:0] out_byte;
    logic [csvfs_pkg::NUM_W-1:0]  out_num;
    logic [csvfs_pkg::LEN_W-1:0]  out_len;
    logic                         out_null;
    logic                         out_ovf;

    csvfs_pkg::t_in_word csv_pending[$];
    t_token              expected_tokens[$];

    int  words_queued = 0;
    int  words_accepted = 0;
    int  tokens_checked = 0;
    int  records_seen = 0;
    int  nulls_seen = 0;
    int  overflows_seen = 0;
    int  mismatches = 0;
    bit  word_taken = 1'b0;
    bit  calm = 1'b0;

    // tokenizer state as the block should hold it
    bit                          null_mode = 1'b0;
    bit                          in_quotes = 1'b0;
    bit                          field_start = 1'b1;
    bit                          quote_held = 1'b0;
    bit                          quoted_field = 1'b0;
    bit                          cr_seen = 1'b0;
    int unsigned                 field_idx = 0;
    logic [csvfs_pkg::LEN_W-1:0] raw_count = '0;
    bit                          record_live = 1'b0;

    csv_field_splitter uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_data_byte     (in_byte),
        .i_end_of_input  (in_eoi),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_kind          (out_kind),
        .o_out_byte      (out_byte),
        .o_field_number  (out_num),
        .o_raw_length    (out_len),
        .o_is_null       (out_null),
        .o_field_overflow(out_ovf)
    );

    always #5 clk = ~clk;

    function automatic void expect_token(logic [csvfs_pkg::KIND_W-1:0] kind,
                                         logic [csvfs_pkg::BYTE_W-1:0] data,
                                         logic [csvfs_pkg::NUM_W-1:0] num,
                                         logic [csvfs_pkg::LEN_W-1:0] len,
                                         logic nul, logic ovf);
        t_token t;
        t.kind = kind;
        t.data = data;
        t.num  = num;
        t.len  = len;
        t.nul  = nul;
        t.ovf  = ovf;
        expected_tokens.push_back(t);
    endfunction

    function automatic void count_raw_byte();
        if (raw_count != csvfs_pkg::LEN_MAX)
            raw_count++;
    endfunction

    function automatic void expect_content(logic [csvfs_pkg::BYTE_W-1:0] b);
        if (field_idx < csvfs_pkg::MAX_FIELDS)
            expect_token(csvfs_pkg::KIND_BYTE, b, field_idx[csvfs_pkg::NUM_W-1:0], '0,
                         1'b0, 1'b0);
    endfunction

    function automatic void expect_field_end(bit ends_record);
        bit ovf;
        bit nul;
        ovf = field_idx >= csvfs_pkg::MAX_FIELDS;
        nul = null_mode && (raw_count == 0 || (quoted_field && raw_count == 2 && !in_quotes));
        if (ends_record) begin
            if (ovf)
                expect_token(csvfs_pkg::KIND_RECORD, '0, csvfs_pkg::NUM_LAST, '0, 1'b0, 1'b1);
            else
                expect_token(csvfs_pkg::KIND_RECORD, '0, field_idx[csvfs_pkg::NUM_W-1:0],
                             raw_count, nul, 1'b0);
            field_idx   = 0;
            record_live = 1'b0;
        end else if (!ovf) begin
            expect_token(csvfs_pkg::KIND_FIELD, '0, field_idx[csvfs_pkg::NUM_W-1:0],
                         raw_count, nul, 1'b0);
            field_idx++;
        end
        raw_count    = '0;
        field_start  = 1'b1;
        quoted_field = 1'b0;
        in_quotes    = 1'b0;
        quote_held   = 1'b0;
    endfunction

    function automatic void tokenize_word(logic [csvfs_pkg::BYTE_W-1:0] b, logic eoi);
        if (eoi) begin
            // a held quote closes the field at end of stream
            if (quote_held) begin
                quote_held = 1'b0;
                in_quotes  = 1'b0;
            end
            cr_seen = 1'b0;
            if (!record_live) begin
                field_idx    = 0;
                raw_count    = '0;
                field_start  = 1'b1;
                quoted_field = 1'b0;
                in_quotes    = 1'b0;
                return;
            end
            expect_field_end(1'b1);
            return;
        end
        if (quote_held) begin
            quote_held = 1'b0;
            if (b == csvfs_pkg::CH_QUOTE) begin
                count_raw_byte();
                expect_content(b);
                return;
            end
            in_quotes = 1'b0;
        end else if (in_quotes) begin
            count_raw_byte();
            if (b == csvfs_pkg::CH_QUOTE) begin
                quote_held = 1'b1;
                return;
            end
            expect_content(b);
            return;
        end
        if (cr_seen) begin
            cr_seen = 1'b0;
            if (b == csvfs_pkg::CH_LF)
                return;
        end
        if (b == csvfs_pkg::CH_CR || b == csvfs_pkg::CH_LF) begin
            if (b == csvfs_pkg::CH_CR)
                cr_seen = 1'b1;
            if (record_live)
                expect_field_end(1'b1);
            return;
        end
        record_live = 1'b1;
        if (b == csvfs_pkg::CH_COMMA) begin
            expect_field_end(1'b0);
            return;
        end
        count_raw_byte();
        if (b == csvfs_pkg::CH_QUOTE && field_start) begin
            in_quotes    = 1'b1;
            quoted_field = 1'b1;
            field_start  = 1'b0;
            return;
        end
        field_start = 1'b0;
        expect_content(b);
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("tb: mismatch at %0t: %s", $time, what);
    endtask

    task automatic check_token();
        t_token want;
        if (expected_tokens.size() == 0) begin
            report_mismatch($sformatf("unexpected word kind %0d byte %02h", out_kind, out_byte));
            return;
        end
        want = expected_tokens.pop_front();
        tokens_checked++;
        if (out_kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_kind, want.kind));
        if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
        if (out_num !== want.num)
            report_mismatch($sformatf("field_number %0d, want %0d", out_num, want.num));
        if (out_len !== want.len)
            report_mismatch($sformatf("raw_length %0d, want %0d", out_len, want.len));
        if (out_null !== want.nul)
            report_mismatch($sformatf("is_null %0b, want %0b", out_null, want.nul));
        if (out_ovf !== want.ovf)
            report_mismatch($sformatf("field_overflow %0b, want %0b", out_ovf, want.ovf));
        if (want.kind == csvfs_pkg::KIND_RECORD)
            records_seen++;
        if (want.nul)
            nulls_seen++;
        if (want.ovf)
            overflows_seen++;
    endtask

    // monitor: input acceptance feeds the predictor, output words are checked
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            tokenize_word(in_byte, in_eoi);
            words_accepted++;
            word_taken = 1'b1;
        end
        if (rst_n && out_valid && out_ready)
            check_token();
    end

    // driver
    always @(negedge clk) begin
        csvfs_pkg::t_in_word w;
        if (!in_valid || word_taken) begin
            word_taken = 1'b0;
            if (rst_n && csv_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 9)) begin
                w = csv_pending.pop_front();
                in_valid <= 1'b1;
                in_byte  <= w.data_byte;
                in_eoi   <= w.end_of_input;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= calm || ($urandom_range(0, 99) >= 9);
    end

    task automatic push_word(logic [csvfs_pkg::BYTE_W-1:0] b, logic eoi);
        csvfs_pkg::t_in_word w;
        w.data_byte    = b;
        w.end_of_input = eoi;
        csv_pending.push_back(w);
        words_queued++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_word(s[i], 1'b0);
    endtask

    task automatic push_end();
        push_word(t_byte'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [csvfs_pkg::BYTE_W-1:0] plain_byte();
        logic [csvfs_pkg::BYTE_W-1:0] b;
        do
            b = t_byte'($urandom_range(0, 255));
        while (b == csvfs_pkg::CH_QUOTE || b == csvfs_pkg::CH_COMMA ||
               b == csvfs_pkg::CH_CR || b == csvfs_pkg::CH_LF);
        return b;
    endfunction

    function automatic logic [csvfs_pkg::BYTE_W-1:0] unquoted_byte();
        logic [csvfs_pkg::BYTE_W-1:0] b;
        do
            b = t_byte'($urandom_range(0, 255));
        while (b == csvfs_pkg::CH_QUOTE);
        return b;
    endfunction

    task automatic push_quoted_body(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: begin
                    push_word(csvfs_pkg::CH_QUOTE, 1'b0);
                    push_word(csvfs_pkg::CH_QUOTE, 1'b0);
                end
                1: push_word(csvfs_pkg::CH_COMMA, 1'b0);
                2: push_word(csvfs_pkg::CH_CR, 1'b0);
                3: push_word(csvfs_pkg::CH_LF, 1'b0);
                default: push_word(unquoted_byte(), 1'b0);
            endcase
        end
    endtask

    task automatic push_field();
        case ($urandom_range(0, 5))
            0: ;
            1: repeat ($urandom_range(1, 8)) push_word(plain_byte(), 1'b0);
            2: begin
                push_word(csvfs_pkg::CH_QUOTE, 1'b0);
                push_quoted_body($urandom_range(0, 8));
                push_word(csvfs_pkg::CH_QUOTE, 1'b0);
            end
            3: push_text("\"\"");
            4: begin
                // literal quote inside an unquoted field
                push_word(plain_byte(), 1'b0);
                push_word(csvfs_pkg::CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 3)) push_word(plain_byte(), 1'b0);
            end
            default: begin
                // bytes trailing a closing quote
                push_word(csvfs_pkg::CH_QUOTE, 1'b0);
                push_quoted_body($urandom_range(0, 4));
                push_word(csvfs_pkg::CH_QUOTE, 1'b0);
                repeat ($urandom_range(1, 3)) push_word(plain_byte(), 1'b0);
            end
        endcase
    endtask

    task automatic push_record();
        int mix;
        int nf;
        int term;
        mix = $urandom_range(0, 99);
        if (mix < 80) begin
            nf = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
            for (int f = 0; f < nf; f++) begin
                if (f != 0)
                    push_word(csvfs_pkg::CH_COMMA, 1'b0);
                push_field();
            end
            term = $urandom_range(0, 9);
            if (term < 5) begin
                push_word(csvfs_pkg::CH_LF, 1'b0);
            end else if (term < 8) begin
                push_word(csvfs_pkg::CH_CR, 1'b0);
                push_word(csvfs_pkg::CH_LF, 1'b0);
            end else if (term < 9) begin
                push_word(csvfs_pkg::CH_CR, 1'b0);
            end else begin
                push_end();
            end
        end else if (mix < 90) begin
            repeat ($urandom_range(1, 10))
                push_word(t_byte'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end else begin
            // unterminated or malformed quoting
            push_word(csvfs_pkg::CH_QUOTE, 1'b0);
            push_quoted_body($urandom_range(0, 4));
            if ($urandom_range(0, 1)) begin
                push_word(csvfs_pkg::CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 2)) push_word(t_byte'($urandom_range(0, 255)), 1'b0);
            end
            if ($urandom_range(0, 1))
                push_end();
            else
                push_word(csvfs_pkg::CH_LF, 1'b0);
        end
    endtask

    task automatic push_random(int n);
        int start;
        start = words_queued;
        while (words_queued - start < n)
            push_record();
    endtask

    task automatic push_directed();
        push_text("\"a\"\"b\",,\"\"");
        push_word(csvfs_pkg::CH_CR, 1'b0);
        push_word(csvfs_pkg::CH_LF, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b0);
        push_text("q\"r,\"c\"d");
        push_word(csvfs_pkg::CH_LF, 1'b0);
        // empty line, then a quoted line break left open at end of stream
        push_word(csvfs_pkg::CH_LF, 1'b0);
        push_text("\"x\n");
        push_end();
        push_text("\"\"");
        push_end();
        push_end();
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (words_accepted != words_queued || expected_tokens.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_null_mode(bit v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        null_mode = v;
    endtask

    initial begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        push_directed();
        wait_drained();
        set_null_mode(1'b1);
        push_directed();
        push_random(180);
        wait_drained();

        set_null_mode(1'b0);
        calm = 1'b1;
        push_random(180);
        // exactly the field limit, then past it with content in the last dropped field
        repeat (csvfs_pkg::MAX_FIELDS - 1) push_word(csvfs_pkg::CH_COMMA, 1'b0);
        push_word(csvfs_pkg::CH_LF, 1'b0);
        repeat (csvfs_pkg::MAX_FIELDS + 2) push_word(csvfs_pkg::CH_COMMA, 1'b0);
        push_text("zz");
        push_word(csvfs_pkg::CH_LF, 1'b0);
        wait_drained();
        calm = 1'b0;

        push_random(180);
        wait_drained();
        set_null_mode(1'b1);
        push_random(180);
        wait_drained();

        repeat (10) @(posedge clk);
        if (expected_tokens.size() != 0)
            report_mismatch($sformatf("%0d expected words never came", expected_tokens.size()));
        $display("tb: %0d input words, %0d output words checked, %0d records", words_accepted,
                 tokens_checked, records_seen);
        $display("tb: null mode 0 and 1, %0d null fields, %0d overflowed records, %0d mismatches",
                 nulls_seen, overflows_seen, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
